@@ src/fcc_pkg.sv @@
// Package for the line code converter: payload types, sequencer states,
// decode and encode lookup tables and the escape sequence bytes.
// No dependencies; imported by fcc_result_queue and the top level.
package fcc_pkg;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic       OP_DECODE = 1'b0;
	localparam logic       OP_ENCODE = 1'b1;
	localparam logic       DEST_TERM = 1'b0;
	localparam logic       DEST_LINE = 1'b1;

	localparam logic [7:0] DEC_NONE   = 8'h00;
	localparam logic [7:0] DEC_COLOUR = 8'h81;
	localparam logic [7:0] DEC_UPPER  = 8'h82;
	localparam logic [7:0] DEC_LOWER  = 8'h83;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] ENC_NONE   = 8'h00;

	localparam logic [5:0] CODE_LOWER_SHIFT = 6'o75;
	localparam logic [5:0] CODE_UPPER_SHIFT = 6'o71;

	localparam logic [3:0] MAX_RESULTS  = 4'd8;
	localparam logic [2:0] ESC_RED_LAST = 3'd4;
	localparam logic [2:0] ESC_DEF_LAST = 3'd7;

	typedef struct packed {
		logic       operation;
		logic [6:0] value;
	} in_item_t;

	typedef struct packed {
		logic       destination;
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PLAN,
		PH_LINE,
		PH_DEC,
		PH_ESC,
		PH_LF,
		PH_FLUSH
	} phase_t;

	// Indexed by {upper_case, code}.
	localparam logic [7:0] DEC_ROM [128] = '{
		8'd0, 8'd0, "e", "8", 8'd0, "|", "a", "3",
		" ", "=", "s", "4", "i", "+", "u", "2",
		DEC_COLOUR, ".", "d", "5", "r", "1", "j", "7",
		"n", ",", "f", "6", "c", "-", "k", 8'd0,
		"t", 8'd0, "z", 8'd8, "l", 8'd9, "w", 8'd0,
		"h", 8'd10, "y", 8'd0, "p", 8'd0, "q", 8'd0,
		"o", 8'd0, "b", 8'd0, "g", 8'd0, "9", 8'd0,
		"m", DEC_UPPER, "x", 8'd0, "v", DEC_LOWER, "0", 8'd0,

		8'd0, 8'd0, "E", "8", 8'd0, "_", "A", "3",
		" ", ":", "S", "4", "I", "/", "U", "2",
		DEC_COLOUR, ")", "D", "5", "R", "1", "J", "7",
		"N", "(", "F", "6", "C", "-", "K", 8'd0,
		"T", 8'd0, "Z", 8'd8, "L", 8'd9, "W", 8'd0,
		"H", 8'd10, "Y", 8'd0, "P", 8'd0, "Q", 8'd0,
		"O", 8'd0, "B", 8'd0, "G", 8'd0, "9", 8'd0,
		"M", DEC_UPPER, "X", 8'd0, "V", DEC_LOWER, "0", 8'd0
	};

	// Bits 5..0 line code, bit 6 needs lower case, bit 7 needs upper case.
	localparam logic [7:0] ENC_ROM [128] = '{
		8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0,
		8'o77, 8'o45, 8'o0, 8'o0, 8'o0, 8'o51, 8'o0, 8'o0,
		8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0,
		8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0,

		8'o10, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0, 8'o0,
		8'o231, 8'o221, 8'o0, 8'o115, 8'o131, 8'o135, 8'o121, 8'o215,
		8'o176, 8'o125, 8'o117, 8'o107, 8'o113, 8'o123, 8'o133, 8'o127,
		8'o103, 8'o166, 8'o0, 8'o0, 8'o0, 8'o111, 8'o0, 8'o0,

		8'o0, 8'o206, 8'o262, 8'o234, 8'o222, 8'o202, 8'o232, 8'o264,
		8'o250, 8'o214, 8'o226, 8'o236, 8'o244, 8'o270, 8'o230, 8'o260,
		8'o254, 8'o256, 8'o224, 8'o212, 8'o240, 8'o216, 8'o274, 8'o246,
		8'o272, 8'o252, 8'o242, 8'o0, 8'o0, 8'o0, 8'o0, 8'o205,

		8'o0, 8'o106, 8'o162, 8'o134, 8'o122, 8'o102, 8'o132, 8'o164,
		8'o150, 8'o114, 8'o126, 8'o136, 8'o144, 8'o170, 8'o130, 8'o160,
		8'o154, 8'o156, 8'o124, 8'o112, 8'o140, 8'o116, 8'o174, 8'o146,
		8'o172, 8'o152, 8'o142, 8'o0, 8'o105, 8'o0, 8'o0, 8'o77
	};

	localparam logic [7:0] ESC_RED [5] = '{8'd27, "[", "3", "1", "m"};
	localparam logic [7:0] ESC_DEF [8] = '{8'd27, "[", "3", "9", ";", "4", "9", "m"};

	function automatic logic [7:0] esc_byte(input logic red, input logic [2:0] idx);
		logic [7:0] b;
		b = ESC_DEF[idx];
		if (red) begin
			case (idx)
				3'd0, 3'd1, 3'd2, 3'd3, 3'd4: b = ESC_RED[idx];
				default: b = 8'd0;
			endcase
		end
		return b;
	endfunction

endpackage

@@ src/fcc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module fcc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/fcc_result_queue.sv @@
// Result queue: results are held in a RAM and drained through a two-entry
// output stage that hides the registered RAM read.
// Depends on fcc_pkg and fcc_ram.
module fcc_result_queue
	import fcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      full,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int unsigned IW = $bits(out_item_t);

	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                inflight_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	out_item_t           out_q;
	out_item_t           skid_q;
	logic [IW-1:0]       rdata;
	out_item_t           rd_item;
	logic                pop;
	logic                issue;
	logic [1:0]          held;

	fcc_ram #(
		.WIDTH(IW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wr_ptr_q),
		.wdata(push_item),
		.re   (issue),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	assign rd_item   = out_item_t'(rdata);
	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop       = out_valid_q && out_ready;
	assign held      = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(inflight_q);
	// The output stage never has to take more than two entries.
	assign issue     = (count_q != '0) && (held <= 2'(1) + 2'(pop));
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
			inflight_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q    <= count_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(issue);
			inflight_q <= issue;
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= inflight_q;
				end else begin
					out_valid_q <= inflight_q;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= inflight_q;
			end else if (inflight_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (inflight_q) begin
					skid_q <= rd_item;
				end
			end else if (inflight_q) begin
				out_q <= rd_item;
			end
		end else if (!out_valid_q) begin
			if (inflight_q) begin
				out_q <= rd_item;
			end
		end else if (inflight_q) begin
			skid_q <= rd_item;
		end
	end

endmodule

@@ src/flexowriter_code_converter_core.sv @@
// Top level of the line code converter: input register, conversion sequencer
// with case and colour flags, and the result queue.
// Depends on fcc_pkg and fcc_result_queue.
//
//   channel   signals                    payload     direction
//   input     in_valid / in_ready        in_item     decode or encode request
//   output    out_valid / out_ready      out_item    terminal byte or line code
//
// The sequencer produces at most one result per cycle, and none while it
// stalls: an item passes a planning step, a step per emitted result or table
// lookup, and a closing step.
// A new item is taken in the closing cycle of the previous one.
// Results wait in a 16-entry RAM queue; the sequencer stalls when it is full.
// Reset clears both flags (lower case, default colour) and empties the queue.
module flexowriter_code_converter_core
	import fcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	phase_t     phase_q, phase_d;
	logic       upper_q, upper_d;
	logic       red_q, red_d;
	logic       pend_valid_q, pend_valid_d;
	logic [3:0] cnt_q, cnt_d;
	logic       op_q, op_d;
	logic [6:0] val_q, val_d;
	logic [5:0] codes_q [2];
	logic [5:0] codes_d [2];
	logic       idx_q, idx_d;
	logic       last_idx_q, last_idx_d;
	logic [2:0] esc_i_q, esc_i_d;
	out_item_t  pend_q, pend_d;

	logic       emit_req;
	logic       emit_dest;
	logic [7:0] emit_data;
	logic       emit_go;
	logic       stall;
	logic       push;
	out_item_t  push_item;
	logic       q_full;
	logic [7:0] dec_entry;
	logic [7:0] enc_entry;

	assign dec_entry = DEC_ROM[{upper_q, codes_q[idx_q]}];
	assign enc_entry = ENC_ROM[val_q];

	always_comb begin
		phase_d      = phase_q;
		upper_d      = upper_q;
		red_d        = red_q;
		pend_valid_d = pend_valid_q;
		cnt_d        = cnt_q;
		op_d         = op_q;
		val_d        = val_q;
		codes_d      = codes_q;
		idx_d        = idx_q;
		last_idx_d   = last_idx_q;
		esc_i_d      = esc_i_q;
		pend_d       = pend_q;
		emit_req     = 1'b0;
		emit_dest    = DEST_TERM;
		emit_data    = 8'd0;
		in_ready     = 1'b0;
		push         = 1'b0;
		push_item    = pend_q;

		case (phase_q)
			PH_IDLE: begin
				in_ready = 1'b1;
			end
			PH_PLAN: begin
				cnt_d = 4'd0;
				idx_d = 1'b0;
				if (op_q == OP_DECODE) begin
					codes_d[0] = val_q[5:0];
					last_idx_d = 1'b0;
					phase_d    = PH_DEC;
				end else if (enc_entry == ENC_NONE) begin
					phase_d = PH_FLUSH;
				end else begin
					phase_d = PH_LINE;
					// A shift code goes out only when the case has to change.
					if (enc_entry[6] && upper_q) begin
						codes_d[0] = CODE_LOWER_SHIFT;
						codes_d[1] = enc_entry[5:0];
						last_idx_d = 1'b1;
					end else if (enc_entry[7] && !upper_q) begin
						codes_d[0] = CODE_UPPER_SHIFT;
						codes_d[1] = enc_entry[5:0];
						last_idx_d = 1'b1;
					end else begin
						codes_d[0] = enc_entry[5:0];
						last_idx_d = 1'b0;
					end
				end
			end
			PH_LINE: begin
				emit_req  = 1'b1;
				emit_dest = DEST_LINE;
				emit_data = {2'b00, codes_q[idx_q]};
				if (idx_q == last_idx_q) begin
					idx_d   = 1'b0;
					phase_d = PH_DEC;
				end else begin
					idx_d = 1'b1;
				end
			end
			PH_DEC: begin
				case (dec_entry)
					DEC_NONE: begin
					end
					DEC_UPPER: begin
						upper_d = 1'b1;
					end
					DEC_LOWER: begin
						upper_d = 1'b0;
					end
					DEC_COLOUR: begin
						red_d = !red_q;
					end
					CHAR_LF: begin
						emit_req  = 1'b1;
						emit_data = CHAR_CR;
					end
					default: begin
						emit_req  = 1'b1;
						emit_data = dec_entry;
					end
				endcase
				if (dec_entry == DEC_COLOUR) begin
					esc_i_d = 3'd0;
					phase_d = PH_ESC;
				end else if (dec_entry == CHAR_LF) begin
					phase_d = PH_LF;
				end else if (idx_q == last_idx_q) begin
					phase_d = PH_FLUSH;
				end else begin
					idx_d = 1'b1;
				end
			end
			PH_ESC: begin
				// The colour flag already holds its new value here.
				emit_req  = 1'b1;
				emit_data = esc_byte(red_q, esc_i_q);
				if (esc_i_q == (red_q ? ESC_RED_LAST : ESC_DEF_LAST)) begin
					if (idx_q == last_idx_q) begin
						phase_d = PH_FLUSH;
					end else begin
						idx_d   = 1'b1;
						phase_d = PH_DEC;
					end
				end else begin
					esc_i_d = esc_i_q + 3'd1;
				end
			end
			PH_LF: begin
				emit_req  = 1'b1;
				emit_data = CHAR_LF;
				if (idx_q == last_idx_q) begin
					phase_d = PH_FLUSH;
				end else begin
					idx_d   = 1'b1;
					phase_d = PH_DEC;
				end
			end
			PH_FLUSH: begin
				// The held result is the item's final one.
				if (!(pend_valid_q && q_full)) begin
					push           = pend_valid_q;
					push_item.last = 1'b1;
					pend_valid_d   = 1'b0;
					in_ready       = 1'b1;
					phase_d        = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (in_valid && in_ready) begin
			op_d    = in_item.operation;
			val_d   = in_item.value;
			phase_d = PH_PLAN;
		end

		// Results past the eighth are dropped; state effects still apply.
		emit_go = emit_req && (cnt_q < MAX_RESULTS);
		stall   = emit_go && pend_valid_q && q_full;
		if (stall) begin
			phase_d = phase_q;
			idx_d   = idx_q;
			esc_i_d = esc_i_q;
		end else if (emit_go) begin
			push             = pend_valid_q;
			push_item        = pend_q;
			pend_d.destination = emit_dest;
			pend_d.data      = emit_data;
			pend_d.last      = 1'b0;
			pend_valid_d     = 1'b1;
			cnt_d            = cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			upper_q      <= 1'b0;
			red_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			cnt_q        <= 4'd0;
		end else begin
			phase_q      <= phase_d;
			upper_q      <= upper_d;
			red_q        <= red_d;
			pend_valid_q <= pend_valid_d;
			cnt_q        <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		val_q      <= val_d;
		codes_q    <= codes_d;
		idx_q      <= idx_d;
		last_idx_q <= last_idx_d;
		esc_i_q    <= esc_i_d;
		pend_q     <= pend_d;
	end

	fcc_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_RESULTS)
		else $error("result count exceeds eight");

	a_ready_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (phase_q == PH_IDLE || phase_q == PH_FLUSH))
		else $error("input ready while an item is in progress");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into a full result queue");

	a_transfer_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (phase_q == PH_PLAN && cnt_q == $past(cnt_q)
		&& !pend_valid_q))
		else $error("input transfer did not start a new item cleanly");
`endif

endmodule
